// ----- rtl/core/sti_pkg.sv -----
// ----------------------------------------------------------------------------
// sti_pkg
// Types and constants shared by the sorted table interpolator modules.
// ----------------------------------------------------------------------------
package sti_pkg;

   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 3;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef logic [OPCODE_W-1:0] opcode_type;
   localparam opcode_type OP_CLEAR  = 2'd0;
   localparam opcode_type OP_APPEND = 2'd1;
   localparam opcode_type OP_LOOKUP = 2'd2;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STAT_OK        = 3'd0;
   localparam status_type STAT_RANGE     = 3'd1;
   localparam status_type STAT_BELOW_MIN = 3'd2;
   localparam status_type STAT_NOT_INCR  = 3'd3;
   localparam status_type STAT_FULL      = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value_a;
      logic [VAL_W-1:0] value_b;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_FETCH_HI,
      ST_HI_DATA,
      ST_LO_DATA,
      ST_INTERP
   } ctl_state_type;

   typedef enum logic [1:0] {
      LANE_IDLE,
      LANE_MUL,
      LANE_DIV,
      LANE_DONE
   } lane_state_type;

endpackage

// ----- rtl/core/sorted_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// sorted_table_interpolator
// Sorted key table with clear, append and interpolating lookup.
//
//   channel | ports                         | transfer
//   --------+-------------------------------+------------------------------
//   request | start, busy, req_*            | start && !busy at clock edge
//   result  | rsp_strobe, rsp_*             | one cycle, rsp_strobe high
//
// Clear, append, unused opcodes and lookups outside the table answer in the
// cycle after the transfer. Other lookups binary-search the entry memory with
// probes of a read then a compare, up to floor(log2(count))+1 probes, then
// read the matching entry. Interpolation reads the low entry, multiplies, runs
// 32 divide steps and finishes; rsp_strobe rises in the cycle busy falls.
// Reset clears the entry count; memory contents need no clearing.
// The result side cannot stall; busy holds off new requests.
// ----------------------------------------------------------------------------
module sorted_table_interpolator #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_opcode,
   input  logic [31:0]  req_entry_key,
   input  logic [31:0]  req_entry_value_a,
   input  logic [31:0]  req_entry_value_b,
   output logic         rsp_strobe,
   output logic [2:0]   rsp_status,
   output logic         rsp_result_valid,
   output logic [31:0]  rsp_result_value_a,
   output logic [31:0]  rsp_result_value_b,
   output logic [31:0]  rsp_largest_key
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = sti_pkg::KEY_W;
   localparam int VW = sti_pkg::VAL_W;

   sti_pkg::ctl_state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [KW-1:0] last_key_ff, last_key_in;
   logic [KW-1:0] first_key_ff, first_key_in;
   logic [KW-1:0] key_ff;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid;
   sti_pkg::entry_type hi_entry_ff;

   logic               accept;
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   sti_pkg::entry_type mem_wr_data;
   sti_pkg::entry_type mem_rd_data;

   logic               lane_start;
   logic               lane_a_done, lane_b_done;
   logic [VW-1:0]      lane_a_result, lane_b_result;
   logic [KW-1:0]      lane_num, lane_den;

   logic               strobe_ff, strobe_in;
   sti_pkg::status_type status_ff, status_in;
   logic               valid_ff, valid_in;
   logic [VW-1:0]      value_a_ff, value_a_in;
   logic [VW-1:0]      value_b_ff, value_b_in;
   logic [KW-1:0]      largest_ff, largest_in;

   assign accept = start && (state_ff == sti_pkg::ST_IDLE);
   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sti_pkg::ST_IDLE: begin
            if (start && req_opcode == sti_pkg::OP_LOOKUP && count_ff != '0 &&
                req_entry_key <= last_key_ff && req_entry_key >= first_key_ff) begin
               state_in = sti_pkg::ST_SEARCH;
            end
         end
         sti_pkg::ST_SEARCH: begin
            state_in = (lo_ff < hi_ff) ? sti_pkg::ST_COMPARE : sti_pkg::ST_FETCH_HI;
         end
         sti_pkg::ST_COMPARE:  state_in = sti_pkg::ST_SEARCH;
         sti_pkg::ST_FETCH_HI: state_in = sti_pkg::ST_HI_DATA;
         sti_pkg::ST_HI_DATA: begin
            if (mem_rd_data.key == key_ff || lo_ff == '0) begin
               state_in = sti_pkg::ST_IDLE;
            end else begin
               state_in = sti_pkg::ST_LO_DATA;
            end
         end
         sti_pkg::ST_LO_DATA: state_in = sti_pkg::ST_INTERP;
         sti_pkg::ST_INTERP: begin
            if (lane_a_done) state_in = sti_pkg::ST_IDLE;
         end
         default: state_in = sti_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      count_in     = count_ff;
      last_key_in  = last_key_ff;
      first_key_in = first_key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mem_wr_en    = 1'b0;
      mem_wr_data  = '{key: req_entry_key, value_a: req_entry_value_a,
                       value_b: req_entry_value_b};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = mid[AW-1:0];
      lane_start   = 1'b0;
      lane_num     = key_ff - mem_rd_data.key;
      lane_den     = hi_entry_ff.key - mem_rd_data.key;
      strobe_in    = 1'b0;
      status_in    = sti_pkg::STAT_OK;
      valid_in     = 1'b0;
      value_a_in   = '0;
      value_b_in   = '0;
      largest_in   = last_key_ff;
      case (state_ff)
         sti_pkg::ST_IDLE: begin
            if (accept) begin
               lo_in = '0;
               hi_in = count_ff;
               case (req_opcode)
                  sti_pkg::OP_CLEAR: begin
                     strobe_in   = 1'b1;
                     count_in    = '0;
                     last_key_in = '0;
                     largest_in  = '0;
                  end
                  sti_pkg::OP_APPEND: begin
                     strobe_in = 1'b1;
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        status_in = sti_pkg::STAT_FULL;
                     end else if (count_ff != '0 && req_entry_key <= last_key_ff) begin
                        status_in = sti_pkg::STAT_NOT_INCR;
                     end else begin
                        mem_wr_en   = 1'b1;
                        count_in    = count_ff + 1'b1;
                        last_key_in = req_entry_key;
                        largest_in  = req_entry_key;
                        if (count_ff == '0) first_key_in = req_entry_key;
                     end
                  end
                  sti_pkg::OP_LOOKUP: begin
                     if (count_ff == '0 || req_entry_key > last_key_ff) begin
                        strobe_in = 1'b1;
                        status_in = sti_pkg::STAT_RANGE;
                     end else if (req_entry_key < first_key_ff) begin
                        strobe_in = 1'b1;
                        status_in = sti_pkg::STAT_BELOW_MIN;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         sti_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en = 1'b1;
            end
         end
         sti_pkg::ST_COMPARE: begin
            // probe address is still mid since lo/hi have not moved
            if (mem_rd_data.key < key_ff) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
         end
         sti_pkg::ST_FETCH_HI: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = lo_ff[AW-1:0];
         end
         sti_pkg::ST_HI_DATA: begin
            if (mem_rd_data.key == key_ff || lo_ff == '0) begin
               strobe_in  = 1'b1;
               valid_in   = 1'b1;
               value_a_in = mem_rd_data.value_a;
               value_b_in = mem_rd_data.value_b;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(lo_ff - 1'b1);
            end
         end
         sti_pkg::ST_LO_DATA: begin
            lane_start = 1'b1;
         end
         sti_pkg::ST_INTERP: begin
            if (lane_a_done && lane_b_done) begin
               strobe_in  = 1'b1;
               valid_in   = 1'b1;
               value_a_in = lane_a_result;
               value_b_in = lane_b_result;
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sti_pkg::ST_IDLE;
         count_ff     <= '0;
         last_key_ff  <= '0;
         first_key_ff <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_key_ff  <= last_key_in;
         first_key_ff <= first_key_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) key_ff <= req_entry_key;
      if (state_ff == sti_pkg::ST_HI_DATA) hi_entry_ff <= mem_rd_data;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      status_ff  <= status_in;
      valid_ff   <= valid_in;
      value_a_ff <= value_a_in;
      value_b_ff <= value_b_in;
      largest_ff <= largest_in;
   end

   sti_table_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sti_interp_lane u_lane_a (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .lo_value (mem_rd_data.value_a),
      .hi_value (hi_entry_ff.value_a),
      .num      (lane_num),
      .den      (lane_den),
      .done     (lane_a_done),
      .result   (lane_a_result)
   );

   sti_interp_lane u_lane_b (
      .clock    (clock),
      .reset    (reset),
      .start    (lane_start),
      .lo_value (mem_rd_data.value_b),
      .hi_value (hi_entry_ff.value_b),
      .num      (lane_num),
      .den      (lane_den),
      .done     (lane_b_done),
      .result   (lane_b_result)
   );

   assign busy               = (state_ff != sti_pkg::ST_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_result_valid   = valid_ff;
   assign rsp_result_value_a = value_a_ff;
   assign rsp_result_value_b = value_b_ff;
   assign rsp_largest_key    = largest_ff;

endmodule

// ----- rtl/core/sti_table_mem.sv -----
// ----------------------------------------------------------------------------
// sti_table_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sti_table_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  sti_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output sti_pkg::entry_type  rd_data
);

   sti_pkg::entry_type mem [DEPTH];
   sti_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sti_interp_lane.sv -----
// ----------------------------------------------------------------------------
// sti_interp_lane
// One value lane: lo + trunc((hi - lo) * num / den), num < den.
// A multiply state, then a 32-step restoring divide.
// ----------------------------------------------------------------------------
module sti_interp_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sti_pkg::VAL_W-1:0]  lo_value,
   input  logic [sti_pkg::VAL_W-1:0]  hi_value,
   input  logic [sti_pkg::KEY_W-1:0]  num,
   input  logic [sti_pkg::KEY_W-1:0]  den,
   output logic                       done,
   output logic [sti_pkg::VAL_W-1:0]  result
);

   localparam int VW = sti_pkg::VAL_W;
   localparam int KW = sti_pkg::KEY_W;

   sti_pkg::lane_state_type state_ff, state_in;

   logic [VW-1:0]   lo_ff;
   logic            neg_ff, neg_in;
   logic [VW-1:0]   mag_ff, mag_in;
   logic [KW-1:0]   num_ff, den_ff;
   logic [KW-1:0]   rem_ff, rem_in;
   logic [KW-1:0]   quo_ff, quo_in;
   logic [sti_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VW:0]     diff;
   logic [VW+KW-1:0] prod;
   logic [KW:0]     trial;
   logic [KW:0]     trial_sub;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sti_pkg::LANE_IDLE: begin
            if (start) state_in = sti_pkg::LANE_MUL;
         end
         sti_pkg::LANE_MUL: state_in = sti_pkg::LANE_DIV;
         sti_pkg::LANE_DIV: begin
            if (cnt_ff == sti_pkg::DIV_CNT_W'(sti_pkg::DIV_STEPS - 1)) begin
               state_in = sti_pkg::LANE_DONE;
            end
         end
         sti_pkg::LANE_DONE: state_in = sti_pkg::LANE_IDLE;
         default: state_in = sti_pkg::LANE_IDLE;
      endcase
   end

   always_comb begin
      diff   = {hi_value[VW-1], hi_value} - {lo_value[VW-1], lo_value};
      neg_in = diff[VW];
      mag_in = neg_in ? VW'(-diff) : diff[VW-1:0];
      prod   = {{KW{1'b0}}, mag_ff} * {{VW{1'b0}}, num_ff};
      // remainder stays below den, so the trial fits one extra bit
      trial     = {rem_ff, quo_ff[KW-1]};
      trial_sub = trial - {1'b0, den_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         sti_pkg::LANE_MUL: begin
            rem_in = prod[VW+KW-1:KW];
            quo_in = prod[KW-1:0];
            cnt_in = '0;
         end
         sti_pkg::LANE_DIV: begin
            if (!trial_sub[KW]) begin
               rem_in = trial_sub[KW-1:0];
               quo_in = {quo_ff[KW-2:0], 1'b1};
            end else begin
               rem_in = trial[KW-1:0];
               quo_in = {quo_ff[KW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sti_pkg::LANE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sti_pkg::LANE_IDLE && start) begin
         lo_ff  <= lo_value;
         neg_ff <= neg_in;
         mag_ff <= mag_in;
         num_ff <= num;
         den_ff <= den;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   // outputs
   always_comb begin
      done   = (state_ff == sti_pkg::LANE_DONE);
      result = neg_ff ? (lo_ff - quo_ff) : (lo_ff + quo_ff);
   end

endmodule
